FILE: rtl/trpm_pkg.sv
// trpm_pkg: shared types and constants of the touch report to pointer mapper
// depends on nothing; used by trpm_div and touch_report_to_pointer_mapper
package trpm_pkg;

  // panel and ui geometry defaults
  localparam int unsigned PanelWidthDef  = 1080;
  localparam int unsigned PanelHeightDef = 2160;
  localparam int unsigned UiHeightDef    = 480;

  // field widths
  localparam int unsigned MaxW    = 16;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned ScaleW  = 4;
  localparam int unsigned UiW     = 11;
  localparam int unsigned PanelW  = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned InDatW  = 32;
  localparam int unsigned OutDatW = 56;

  // shared divider: the quotient fits in the panel coordinate width
  localparam int unsigned DivNumW   = MaxW + PanelW;
  localparam int unsigned DivDenW   = MaxW;
  localparam int unsigned DivQuoW   = PanelW;
  localparam int unsigned DivCntW   = $clog2(DivQuoW + 1);

  // status codes
  localparam logic [2:0] StatEnter  = 3'd1;
  localparam logic [2:0] StatMoving = 3'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegMaxX    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxY    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRectX0  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRectY0  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRectW   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRectH   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegUiScale = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUiWidth = 3'd7;

  // register reset values
  localparam logic [MaxW-1:0]   MaxXRst    = 16'd1080;
  localparam logic [MaxW-1:0]   MaxYRst    = 16'd2160;
  localparam logic [CoordW-1:0] RectX0Rst  = 12'd60;
  localparam logic [CoordW-1:0] RectY0Rst  = 12'd440;
  localparam logic [CoordW-1:0] RectWRst   = 12'd960;
  localparam logic [CoordW-1:0] RectHRst   = 12'd1280;
  localparam logic [ScaleW-1:0] UiScaleRst = 4'd2;
  localparam logic [UiW-1:0]    UiWidthRst = 11'd640;
  localparam logic [UiW-1:0]    PtrXRst    = 11'd320;

  typedef struct packed {
    logic                start;
    logic [DivNumW-1:0]  num;
    logic [DivDenW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DivQuoW-1:0]  quo;
  } div_rsp_t;

endpackage

FILE: rtl/trpm_div.sv
// trpm_div: shared restoring divider, one quotient bit per cycle
// depends on trpm_pkg; requires num < den * 2**DivQuoW
module trpm_div
  import trpm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivQuoW-1:0] nq_q, nq_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivDenW:0]   trial;
  logic               fits;

  assign trial = {rem_q, nq_q[DivQuoW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    nq_d   = nq_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      rem_d = fits ? DivDenW'(trial - {1'b0, den_q}) : DivDenW'(trial);
      nq_d  = {nq_q[DivQuoW-2:0], fits};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      // upper part is already below the divisor
      rem_d  = req_i.num[DivNumW-1:DivQuoW];
      nq_d   = req_i.num[DivQuoW-1:0];
      den_d  = req_i.den;
      cnt_d  = DivCntW'(DivQuoW);
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = nq_q;

endmodule

FILE: rtl/touch_report_to_pointer_mapper.sv
// touch_report_to_pointer_mapper: finger report decode, scale, clamp, rotate
// release and out-of-range reports go straight to the pointer beat, while an in-range
// contact makes four passes through the shared 12-step divider plus the MULX, MULY, CLAMP
// and DONE steps; one report is in work at a time and the next is taken the cycle after
// the pointer beat is loaded.
// reset restores register defaults and centers the pointer; needs trpm_pkg, trpm_div
module touch_report_to_pointer_mapper
  import trpm_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = PanelWidthDef,
  parameter int unsigned PANEL_HEIGHT = PanelHeightDef,
  parameter int unsigned UI_HEIGHT    = UiHeightDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  // report beats
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // status_byte, x_high, y_high, low_nibbles
  input  logic [InDatW-1:0]  s_axis_tdata,
  // pointer beats
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // pointer_valid, ui_x, ui_y, button, raw_x, raw_y, raw_down, zero fill
  output logic [OutDatW-1:0] m_axis_tdata
);

  localparam logic [PanelW-1:0] PanelWC = PanelW'(PANEL_WIDTH);
  localparam logic [PanelW-1:0] PanelHC = PanelW'(PANEL_HEIGHT);
  localparam logic [UiW-1:0]    UiHMax  = UiW'(UI_HEIGHT - 1);
  localparam logic [UiW-1:0]    PtrYRst = UiW'(UI_HEIGHT / 2);

  typedef enum logic [3:0] {
    S_IDLE, S_MULX, S_DIVX, S_MULY, S_DIVY, S_CLAMP, S_DIVPY, S_DIVPX, S_DONE
  } state_e;

  // configuration registers
  logic [MaxW-1:0]   max_x_q, max_y_q;
  logic [CoordW-1:0] rect_x0_q, rect_y0_q, rect_w_q, rect_h_q;
  logic [ScaleW-1:0] ui_scale_q;
  logic [UiW-1:0]    ui_width_q;

  state_e             state_q;
  logic               was_down_q, lat_down_q;
  logic [UiW-1:0]     ptr_x_q, ptr_y_q;
  logic [CoordW-1:0]  lat_x_q, lat_y_q;
  logic               res_valid_q, res_btn_q;
  logic [PanelW-1:0]  qx_q, qy_q;
  logic [CoordW-1:0]  px_q, py_q;
  logic               m_valid_q, m_valid_d;
  logic [OutDatW-1:0] m_data_q;
  logic               div_start_q, div_start_d;
  logic [DivNumW-1:0] div_num_q;
  logic [DivDenW-1:0] div_den_q;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // input decode
  logic [2:0]        in_stat;
  logic [CoordW-1:0] in_x, in_y;
  logic              in_contact, in_range;
  assign in_stat    = s_axis_tdata[2:0];
  assign in_x       = {s_axis_tdata[15:8], s_axis_tdata[31:28]};
  assign in_y       = {s_axis_tdata[23:16], s_axis_tdata[27:24]};
  assign in_contact = (in_stat == StatEnter) || (in_stat == StatMoving);
  assign in_range   = ({4'd0, in_x} <= max_x_q) && ({4'd0, in_y} <= max_y_q);

  assign s_axis_tready = (state_q == S_IDLE);

  // shared multiplier: inverted axis times panel size
  logic              mul_y;
  logic [MaxW-1:0]   mul_a;
  logic [PanelW-1:0] mul_b;
  logic [DivNumW-1:0] mul_p;
  assign mul_y = (state_q == S_MULY);
  assign mul_a = mul_y ? (max_y_q - {4'd0, lat_y_q}) : (max_x_q - {4'd0, lat_x_q});
  assign mul_b = mul_y ? PanelHC : PanelWC;
  assign mul_p = DivNumW'(mul_a) * DivNumW'(mul_b);

  // zero substitutions
  logic [DivDenW-1:0] den_x, den_y;
  logic [CoordW-1:0]  w_max, h_max;
  logic [ScaleW-1:0]  sc;
  logic [UiW-1:0]     uw_max;
  assign den_x  = (max_x_q == '0) ? DivDenW'(PanelWC) : max_x_q;
  assign den_y  = (max_y_q == '0) ? DivDenW'(PanelHC) : max_y_q;
  assign w_max  = (rect_w_q == '0) ? '0 : rect_w_q - CoordW'(1);
  assign h_max  = (rect_h_q == '0) ? '0 : rect_h_q - CoordW'(1);
  assign sc     = (ui_scale_q == '0) ? ScaleW'(1) : ui_scale_q;
  assign uw_max = (ui_width_q == '0) ? '0 : ui_width_q - UiW'(1);

  // offset into the ui rectangle and clamp
  logic [CoordW:0]   ox, oy;
  logic [CoordW-1:0] px_c, py_c;
  assign ox = {1'b0, qx_q} - {1'b0, rect_x0_q};
  assign oy = {1'b0, qy_q} - {1'b0, rect_y0_q};
  always_comb begin
    if (ox[CoordW])                 px_c = '0;
    else if (ox[CoordW-1:0] > w_max) px_c = w_max;
    else                            px_c = ox[CoordW-1:0];
    if (oy[CoordW])                 py_c = '0;
    else if (oy[CoordW-1:0] > h_max) py_c = h_max;
    else                            py_c = oy[CoordW-1:0];
  end

  // rotation and ui clamp on divider results
  logic [UiW-1:0] rx_c, ry_c;
  assign rx_c = (div_rsp.quo > {1'b0, uw_max}) ? '0 : UiW'({1'b0, uw_max} - div_rsp.quo);
  assign ry_c = (div_rsp.quo > {1'b0, UiHMax}) ? UiHMax : div_rsp.quo[UiW-1:0];

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  // divider kick and output beat valid
  assign div_start_d = (state_q == S_MULX) || (state_q == S_MULY) || (state_q == S_CLAMP) ||
                       ((state_q == S_DIVPY) && div_rsp.done);
  assign m_valid_d   = ((state_q == S_DONE) && out_free) || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_x_q    <= MaxXRst;
      max_y_q    <= MaxYRst;
      rect_x0_q  <= RectX0Rst;
      rect_y0_q  <= RectY0Rst;
      rect_w_q   <= RectWRst;
      rect_h_q   <= RectHRst;
      ui_scale_q <= UiScaleRst;
      ui_width_q <= UiWidthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMaxX:    max_x_q    <= cfg_data_i;
        RegMaxY:    max_y_q    <= cfg_data_i;
        RegRectX0:  rect_x0_q  <= cfg_data_i[CoordW-1:0];
        RegRectY0:  rect_y0_q  <= cfg_data_i[CoordW-1:0];
        RegRectW:   rect_w_q   <= cfg_data_i[CoordW-1:0];
        RegRectH:   rect_h_q   <= cfg_data_i[CoordW-1:0];
        RegUiScale: ui_scale_q <= cfg_data_i[ScaleW-1:0];
        RegUiWidth: ui_width_q <= cfg_data_i[UiW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      was_down_q  <= 1'b0;
      lat_down_q  <= 1'b0;
      ptr_x_q     <= PtrXRst;
      ptr_y_q     <= PtrYRst;
      lat_x_q     <= '0;
      lat_y_q     <= '0;
      res_valid_q <= 1'b0;
      res_btn_q   <= 1'b0;
      qx_q        <= '0;
      qy_q        <= '0;
      px_q        <= '0;
      py_q        <= '0;
      m_valid_q   <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= div_start_d;
      m_valid_q   <= m_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            res_btn_q <= in_contact;
            if (!in_contact) begin
              lat_down_q  <= 1'b0;
              res_valid_q <= was_down_q;
              was_down_q  <= 1'b0;
              state_q     <= S_DONE;
            end else begin
              lat_x_q     <= in_x;
              lat_y_q     <= in_y;
              lat_down_q  <= 1'b1;
              was_down_q  <= 1'b1;
              res_valid_q <= in_range;
              state_q     <= in_range ? S_MULX : S_DONE;
            end
          end
        end
        S_MULX: begin
          state_q <= S_DIVX;
        end
        S_DIVX: begin
          if (div_rsp.done) begin
            qx_q    <= div_rsp.quo;
            state_q <= S_MULY;
          end
        end
        S_MULY: begin
          state_q <= S_DIVY;
        end
        S_DIVY: begin
          if (div_rsp.done) begin
            qy_q    <= div_rsp.quo;
            state_q <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          px_q    <= px_c;
          py_q    <= py_c;
          state_q <= S_DIVPY;
        end
        S_DIVPY: begin
          if (div_rsp.done) begin
            ptr_x_q <= rx_c;
            state_q <= S_DIVPX;
          end
        end
        S_DIVPX: begin
          if (div_rsp.done) begin
            ptr_y_q <= ry_c;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // divider operands and output word
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_MULX: begin
        div_num_q <= mul_p;
        div_den_q <= den_x;
      end
      S_MULY: begin
        div_num_q <= mul_p;
        div_den_q <= den_y;
      end
      S_CLAMP: begin
        div_num_q <= DivNumW'(py_c);
        div_den_q <= DivDenW'(sc);
      end
      S_DIVPY: begin
        div_num_q <= DivNumW'(px_q);
      end
      S_DONE: begin
        if (out_free) begin
          m_data_q <= {7'd0, lat_down_q, lat_y_q, lat_x_q,
                       res_valid_q & res_btn_q,
                       res_valid_q ? ptr_y_q : UiW'(0),
                       res_valid_q ? ptr_x_q : UiW'(0),
                       res_valid_q};
        end
      end
      default: ;
    endcase
  end

  assign div_req = {div_start_q, div_num_q, div_den_q};

  trpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
